/* rtl/exbdf_pkg.sv */
// ----------------------------------------------------------------------------
// exbdf_pkg
// Shared types and constants for the bus frame deframer.
// ----------------------------------------------------------------------------
package exbdf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 6;
  localparam int unsigned CfgIdxW    = 2;

  // Length byte limits, and the length taken by header and CRC bytes around data
  localparam logic [ByteW-1:0] MaxFrameLen = 8'd40;
  localparam logic [ByteW-1:0] MinFrameLen = 8'd8;
  localparam logic [PosW-1:0]  FrameOvhd   = 6'd8;
  // Frame position of the first byte after the data-length byte
  localparam logic [PosW-1:0]  BodyPos     = 6'd6;

  // Fixed positions of the header bytes
  localparam logic [PosW-1:0] PosHdr1  = 6'd0;
  localparam logic [PosW-1:0] PosHdr2  = 6'd1;
  localparam logic [PosW-1:0] PosLen   = 6'd2;
  localparam logic [PosW-1:0] PosPid   = 6'd3;
  localparam logic [PosW-1:0] PosDtype = 6'd4;
  localparam logic [PosW-1:0] PosDlen  = 6'd5;

  // Register reset values
  localparam logic [ByteW-1:0] Hdr1ARst = 8'd62;
  localparam logic [ByteW-1:0] Hdr1BRst = 8'd61;
  localparam logic [ByteW-1:0] Hdr2ARst = 8'd1;
  localparam logic [ByteW-1:0] Hdr2BRst = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    RegHdr1A = 2'd0,
    RegHdr1B = 2'd1,
    RegHdr2A = 2'd2,
    RegHdr2B = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhHdr2  = 3'd1,
    PhLen   = 3'd2,
    PhPid   = 3'd3,
    PhDtype = 3'd4,
    PhDlen  = 3'd5,
    PhBody  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] hdr1_a;
    logic [ByteW-1:0] hdr1_b;
    logic [ByteW-1:0] hdr2_a;
    logic [ByteW-1:0] hdr2_b;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic [PosW-1:0]  frame_position;
    logic             in_frame;
    logic             frame_end;
    logic             frame_abort;
  } res_t;

endpackage

/* rtl/exbus_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// exbus_frame_deframer_unit
// Byte-stream frame deframer with header, length and data-length checks.
// ----------------------------------------------------------------------------
// Each received byte goes in on the slave stream and comes out on the master
// stream tagged with its position in the frame and in-frame, frame-end and
// abort flags, one transaction out for each transaction in. Throughput is one
// byte per clock while the master stream does not stall: the byte is held in
// an input register, the phase tracker classifies it and updates its state in
// the same cycle, and the result is held in an output register until the
// master stream takes it.
// The CRC bytes are passed through unchecked.
// The four header match registers are written on the cfg channel (always
// ready) and must only be changed while no byte is in flight.
// ----------------------------------------------------------------------------
module exbus_frame_deframer_unit import exbdf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  // received byte stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  // tagged byte stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // [7:0] byte_out, [13:8] frame_position, rest 0
  output logic [1:0]         m_axis_tuser,   // [0] in_frame, [1] frame_abort
  output logic               m_axis_tlast    // frame_end
);

  cfg_t             cfg;
  res_t             res;

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  res_t             out_res_q;
  logic             step;
  logic             take_in;

  assign cfg_ready_o = 1'b1;

  exbdf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input stage moves on when the output slot is free or being drained
  assign step          = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | step;
  assign take_in       = s_axis_tvalid & s_axis_tready;

  assign in_vld_d  = take_in | (in_vld_q & ~step);
  assign out_vld_d = step | (out_vld_q & ~m_axis_tready);

  exbdf_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_res_q.frame_position, out_res_q.byte_out};
  assign m_axis_tuser  = {out_res_q.frame_abort, out_res_q.in_frame};
  assign m_axis_tlast  = out_res_q.frame_end;

endmodule

/* rtl/exbdf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// exbdf_cfg_regs
// Header match registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module exbdf_cfg_regs import exbdf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegHdr1A: cfg_d.hdr1_a = cfg_data_i;
        RegHdr1B: cfg_d.hdr1_b = cfg_data_i;
        RegHdr2A: cfg_d.hdr2_a = cfg_data_i;
        RegHdr2B: cfg_d.hdr2_b = cfg_data_i;
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{hdr1_a: Hdr1ARst, hdr1_b: Hdr1BRst, hdr2_a: Hdr2ARst, hdr2_b: Hdr2BRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/exbdf_fsm.sv */
// ----------------------------------------------------------------------------
// exbdf_fsm
// Frame phase tracker: classifies one byte per step and updates state.
// ----------------------------------------------------------------------------
module exbdf_fsm import exbdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,   // byte consumed this cycle
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] body_cnt_q, body_cnt_d;
  logic [PosW-1:0] frame_len_q, frame_len_d;
  logic [PosW-1:0] pay_len_q, pay_len_d;

  logic [PosW:0]   body_lim;
  logic [PosW-1:0] dlen_exp;

  assign body_lim = {1'b0, pay_len_q} + {{PosW{1'b0}}, 1'b1};
  assign dlen_exp = frame_len_q - FrameOvhd;

  always_comb begin
    phase_d      = phase_q;
    body_cnt_d   = body_cnt_q;
    frame_len_d  = frame_len_q;
    pay_len_d    = pay_len_q;
    res_o        = '0;
    res_o.byte_out = byte_i;

    unique case (phase_q)
      PhHdr2: begin
        res_o.frame_position = PosHdr2;
        if (byte_i == cfg_i.hdr2_a || byte_i == cfg_i.hdr2_b) begin
          res_o.in_frame = 1'b1;
          phase_d        = PhLen;
        end else begin
          res_o.frame_abort = 1'b1;
          phase_d           = PhHunt;
        end
      end
      PhLen: begin
        res_o.frame_position = PosLen;
        if (byte_i >= MinFrameLen && byte_i <= MaxFrameLen) begin
          res_o.in_frame = 1'b1;
          frame_len_d    = byte_i[PosW-1:0];
          phase_d        = PhPid;
        end else begin
          res_o.frame_abort = 1'b1;
          phase_d           = PhHunt;
        end
      end
      PhPid: begin
        res_o.frame_position = PosPid;
        res_o.in_frame       = 1'b1;
        phase_d              = PhDtype;
      end
      PhDtype: begin
        res_o.frame_position = PosDtype;
        res_o.in_frame       = 1'b1;
        phase_d              = PhDlen;
      end
      PhDlen: begin
        res_o.frame_position = PosDlen;
        if (frame_len_q >= FrameOvhd &&
            byte_i == {{(ByteW-PosW){1'b0}}, dlen_exp}) begin
          res_o.in_frame = 1'b1;
          pay_len_d      = byte_i[PosW-1:0];
          body_cnt_d     = '0;
          phase_d        = PhBody;
        end else begin
          res_o.frame_abort = 1'b1;
          phase_d           = PhHunt;
        end
      end
      PhBody: begin
        res_o.frame_position = BodyPos + body_cnt_q;
        res_o.in_frame       = 1'b1;
        // second CRC byte closes the frame
        if ({1'b0, body_cnt_q} >= body_lim) begin
          res_o.frame_end = 1'b1;
          phase_d         = PhHunt;
        end else begin
          body_cnt_d = body_cnt_q + 1'b1;
        end
      end
      default: begin
        // hunting; any stray code behaves the same
        res_o.frame_position = PosHdr1;
        phase_d              = PhHunt;
        if (byte_i == cfg_i.hdr1_a || byte_i == cfg_i.hdr1_b) begin
          res_o.in_frame = 1'b1;
          body_cnt_d     = '0;
          phase_d        = PhHdr2;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      body_cnt_q  <= '0;
      frame_len_q <= '0;
      pay_len_q   <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      body_cnt_q  <= body_cnt_d;
      frame_len_q <= frame_len_d;
      pay_len_q   <= pay_len_d;
    end
  end

endmodule
